@@ hw/rtl/bfl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfl_pkg - shared definitions for the BFS level finder
// Sizes, field types, command codes and the request/response bundles
// that pass between the controller and the two storage blocks.
// ----------------------------------------------------------------------------
package bfl_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_SLOTS = 512;

    localparam int NODE_W  = 6;
    localparam int LVL_W   = 6;
    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LINK_W  = $clog2(MAX_SLOTS + 1);
    localparam int QPTR_W  = $clog2(MAX_NODES + 1);

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [NODE_AW-1:0] node_addr_t;
    typedef logic [SLOT_AW-1:0] slot_addr_t;
    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [QPTR_W-1:0]  qptr_t;

    typedef enum logic [1:0] {
        MODE_EDGE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef struct packed {
        logic       head_rd;
        node_addr_t head_rd_addr;
        logic       head_wr;
        node_addr_t head_wr_addr;
        link_t      head_wr_link;
        logic       head_clear;
        logic       slot_rd;
        slot_addr_t slot_rd_addr;
        logic       slot_wr;
        slot_addr_t slot_wr_addr;
        node_t      slot_wr_target;
        link_t      slot_wr_next;
    } graph_req_t;

    typedef struct packed {
        link_t head_link;
        node_t slot_target;
        link_t slot_next;
    } graph_rsp_t;

    typedef struct packed {
        logic       vis_clear;
        logic       vis_set;
        node_addr_t vis_set_addr;
        logic       lvl_wr;
        node_addr_t lvl_wr_addr;
        lvl_t       lvl_wr_val;
        logic       lvl_rd;
        node_addr_t lvl_rd_addr;
        logic       q_wr;
        node_addr_t q_wr_addr;
        node_t      q_wr_node;
        lvl_t       q_wr_lvl;
        logic       q_rd;
        node_addr_t q_rd_addr;
    } srch_req_t;

    typedef struct packed {
        logic [MAX_NODES-1:0] visited;
        lvl_t                 lvl_rdata;
        node_t                q_node;
        lvl_t                 q_lvl;
    } srch_rsp_t;

    function automatic logic node_ok(input node_t n);
        return int'(n) < MAX_NODES;
    endfunction

    function automatic node_addr_t node_addr(input node_t n);
        return node_addr_t'(n);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bfs_level_finder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_level_finder - breadth-first hop levels over a stored graph
// Stores undirected edges in adjacency lists, walks from a root on a run
// request and returns every reached node with its level, in node order.
// ----------------------------------------------------------------------------
// One request at a time. An edge reads and rewrites the list head of each end
// in turn. A run marks its root, then walks the queue, reading each node's
// list head and then its adjacency slots from the slot store, then scans
// node indices up to the highest reached node and reads the level of each
// reached node; the result side may stall it. Results sit in an output
// register, so the next request is taken while the last result of a run
// still waits. The overflow bit is sticky until reset.
// ----------------------------------------------------------------------------
module bfs_level_finder
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire logic [1:0]                 mode,
    input  wire logic [bfl_pkg::NODE_W-1:0] node_a,
    input  wire logic [bfl_pkg::NODE_W-1:0] node_b,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic [bfl_pkg::NODE_W-1:0]      node_id,
    output logic [bfl_pkg::LVL_W-1:0]       hop_level,
    output logic                            last,
    output logic                            overflow
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_A,
        S_READ_B,
        S_EDGE_B,
        S_DEQ,
        S_QWAIT,
        S_HEAD,
        S_SLOT,
        S_SCAN,
        S_LWAIT
    } state_t;

    state_t               state_reg, state_next;
    bfl_pkg::node_t       a_reg, a_next;
    bfl_pkg::node_t       b_reg, b_next;
    bfl_pkg::link_t       slots_used_reg, slots_used_next;
    logic                 ovf_reg, ovf_next;
    bfl_pkg::qptr_t       qh_reg, qh_next;
    bfl_pkg::qptr_t       qt_reg, qt_next;
    bfl_pkg::lvl_t        cur_lvl_reg, cur_lvl_next;
    bfl_pkg::node_addr_t  idx_reg, idx_next;
    bfl_pkg::qptr_t       emit_cnt_reg, emit_cnt_next;
    logic                 res_valid_reg, res_valid_next;
    bfl_pkg::node_t       res_node_reg, res_node_next;
    bfl_pkg::lvl_t        res_lvl_reg, res_lvl_next;
    logic                 res_last_reg, res_last_next;
    logic                 res_ovf_reg, res_ovf_next;

    bfl_pkg::graph_req_t  greq;
    bfl_pkg::graph_rsp_t  grsp;
    bfl_pkg::srch_req_t   sreq;
    bfl_pkg::srch_rsp_t   srsp;

    logic                 head_live;
    logic                 next_live;
    logic                 emit_last;
    bfl_pkg::lvl_t        lvl_inc;
    bfl_pkg::node_t       tgt;

    bfl_graph u_graph
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (greq),
        .rsp   (grsp)
    );

    bfl_search u_search
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    assign cmd_ready = (state_reg == S_IDLE);

    // A link is followed only while it points at a slot in use
    assign head_live = (grsp.head_link != '0) && (grsp.head_link <= slots_used_reg);
    assign next_live = (grsp.slot_next != '0) && (grsp.slot_next <= slots_used_reg);
    assign emit_last = ((emit_cnt_reg + bfl_pkg::QPTR_W'(1)) == qt_reg);
    assign lvl_inc   = cur_lvl_reg + bfl_pkg::LVL_W'(1);
    assign tgt       = grsp.slot_target;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        slots_used_next = slots_used_reg;
        ovf_next        = ovf_reg;
        qh_next         = qh_reg;
        qt_next         = qt_reg;
        cur_lvl_next    = cur_lvl_reg;
        idx_next        = idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        res_valid_next  = res_valid_reg;
        res_node_next   = res_node_reg;
        res_lvl_next    = res_lvl_reg;
        res_last_next   = res_last_reg;
        res_ovf_next    = res_ovf_reg;
        greq            = '0;
        sreq            = '0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    a_next = node_a;
                    b_next = node_b;
                    unique case (bfl_pkg::mode_t'(mode))
                        bfl_pkg::MODE_EDGE:
                        begin
                            if (bfl_pkg::node_ok(node_a) && bfl_pkg::node_ok(node_b))
                            begin
                                if (int'(slots_used_reg) + 2 > bfl_pkg::MAX_SLOTS)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    greq.head_rd      = 1'b1;
                                    greq.head_rd_addr = bfl_pkg::node_addr(node_a);
                                    state_next        = S_EDGE_A;
                                end
                            end
                        end
                        bfl_pkg::MODE_RUN:
                        begin
                            sreq.vis_clear = 1'b1;
                            if (bfl_pkg::node_ok(node_a))
                            begin
                                sreq.vis_set      = 1'b1;
                                sreq.vis_set_addr = bfl_pkg::node_addr(node_a);
                                sreq.lvl_wr       = 1'b1;
                                sreq.lvl_wr_addr  = bfl_pkg::node_addr(node_a);
                                sreq.lvl_wr_val   = '0;
                                sreq.q_wr         = 1'b1;
                                sreq.q_wr_addr    = '0;
                                sreq.q_wr_node    = node_a;
                                sreq.q_wr_lvl     = '0;
                                qh_next           = '0;
                                qt_next           = bfl_pkg::QPTR_W'(1);
                                state_next        = S_DEQ;
                            end
                        end
                        bfl_pkg::MODE_CLEAR:
                        begin
                            greq.head_clear = 1'b1;
                            slots_used_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_EDGE_A:
            begin
                greq.slot_wr        = 1'b1;
                greq.slot_wr_addr   = bfl_pkg::slot_addr_t'(slots_used_reg);
                greq.slot_wr_target = b_reg;
                greq.slot_wr_next   = grsp.head_link;
                greq.head_wr        = 1'b1;
                greq.head_wr_addr   = bfl_pkg::node_addr(a_reg);
                greq.head_wr_link   = slots_used_reg + bfl_pkg::LINK_W'(1);
                slots_used_next     = slots_used_reg + bfl_pkg::LINK_W'(1);
                state_next          = S_READ_B;
            end

            // Read the second head only after the first write has landed
            S_READ_B:
            begin
                greq.head_rd      = 1'b1;
                greq.head_rd_addr = bfl_pkg::node_addr(b_reg);
                state_next        = S_EDGE_B;
            end

            S_EDGE_B:
            begin
                greq.slot_wr        = 1'b1;
                greq.slot_wr_addr   = bfl_pkg::slot_addr_t'(slots_used_reg);
                greq.slot_wr_target = a_reg;
                greq.slot_wr_next   = grsp.head_link;
                greq.head_wr        = 1'b1;
                greq.head_wr_addr   = bfl_pkg::node_addr(b_reg);
                greq.head_wr_link   = slots_used_reg + bfl_pkg::LINK_W'(1);
                slots_used_next     = slots_used_reg + bfl_pkg::LINK_W'(1);
                state_next          = S_IDLE;
            end

            S_DEQ:
            begin
                if (qh_reg == qt_reg)
                begin
                    idx_next      = '0;
                    emit_cnt_next = '0;
                    state_next    = S_SCAN;
                end
                else
                begin
                    sreq.q_rd      = 1'b1;
                    sreq.q_rd_addr = qh_reg[bfl_pkg::NODE_AW-1:0];
                    qh_next        = qh_reg + bfl_pkg::QPTR_W'(1);
                    state_next     = S_QWAIT;
                end
            end

            S_QWAIT:
            begin
                cur_lvl_next      = srsp.q_lvl;
                greq.head_rd      = 1'b1;
                greq.head_rd_addr = bfl_pkg::node_addr(srsp.q_node);
                state_next        = S_HEAD;
            end

            S_HEAD:
            begin
                if (head_live)
                begin
                    greq.slot_rd      = 1'b1;
                    greq.slot_rd_addr =
                        bfl_pkg::slot_addr_t'(grsp.head_link - bfl_pkg::LINK_W'(1));
                    state_next        = S_SLOT;
                end
                else
                begin
                    state_next = S_DEQ;
                end
            end

            // One slot per cycle: take the target, fetch the next link
            S_SLOT:
            begin
                if (bfl_pkg::node_ok(tgt) && !srsp.visited[bfl_pkg::node_addr(tgt)]
                    && (int'(qt_reg) < bfl_pkg::MAX_NODES))
                begin
                    sreq.vis_set      = 1'b1;
                    sreq.vis_set_addr = bfl_pkg::node_addr(tgt);
                    sreq.lvl_wr       = 1'b1;
                    sreq.lvl_wr_addr  = bfl_pkg::node_addr(tgt);
                    sreq.lvl_wr_val   = lvl_inc;
                    sreq.q_wr         = 1'b1;
                    sreq.q_wr_addr    = qt_reg[bfl_pkg::NODE_AW-1:0];
                    sreq.q_wr_node    = tgt;
                    sreq.q_wr_lvl     = lvl_inc;
                    qt_next           = qt_reg + bfl_pkg::QPTR_W'(1);
                end
                if (next_live)
                begin
                    greq.slot_rd      = 1'b1;
                    greq.slot_rd_addr =
                        bfl_pkg::slot_addr_t'(grsp.slot_next - bfl_pkg::LINK_W'(1));
                end
                else
                begin
                    state_next = S_DEQ;
                end
            end

            S_SCAN:
            begin
                if (srsp.visited[idx_reg])
                begin
                    sreq.lvl_rd      = 1'b1;
                    sreq.lvl_rd_addr = idx_reg;
                    state_next       = S_LWAIT;
                end
                else
                begin
                    idx_next = idx_reg + bfl_pkg::NODE_AW'(1);
                end
            end

            // Hold the level until the output register is free
            S_LWAIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_node_next  = bfl_pkg::node_t'(idx_reg);
                    res_lvl_next   = srsp.lvl_rdata;
                    res_last_next  = emit_last;
                    res_ovf_next   = ovf_reg;
                    emit_cnt_next  = emit_cnt_reg + bfl_pkg::QPTR_W'(1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + bfl_pkg::NODE_AW'(1);
                        state_next = S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            a_reg          <= '0;
            b_reg          <= '0;
            slots_used_reg <= '0;
            ovf_reg        <= 1'b0;
            qh_reg         <= '0;
            qt_reg         <= '0;
            cur_lvl_reg    <= '0;
            idx_reg        <= '0;
            emit_cnt_reg   <= '0;
            res_valid_reg  <= 1'b0;
            res_node_reg   <= '0;
            res_lvl_reg    <= '0;
            res_last_reg   <= 1'b0;
            res_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            slots_used_reg <= slots_used_next;
            ovf_reg        <= ovf_next;
            qh_reg         <= qh_next;
            qt_reg         <= qt_next;
            cur_lvl_reg    <= cur_lvl_next;
            idx_reg        <= idx_next;
            emit_cnt_reg   <= emit_cnt_next;
            res_valid_reg  <= res_valid_next;
            res_node_reg   <= res_node_next;
            res_lvl_reg    <= res_lvl_next;
            res_last_reg   <= res_last_next;
            res_ovf_reg    <= res_ovf_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign node_id   = res_node_reg;
    assign hop_level = res_lvl_reg;
    assign last      = res_last_reg;
    assign overflow  = res_ovf_reg;

endmodule
`default_nettype wire

@@ hw/rtl/bfl_graph.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfl_graph - adjacency store
// List heads per node (with valid bits so that a clear resets them all at once)
// and the slot store of targets and links. Read data is registered.
// ----------------------------------------------------------------------------
module bfl_graph
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bfl_pkg::graph_req_t req,
    output bfl_pkg::graph_rsp_t     rsp
);

    bfl_pkg::link_t head_mem [bfl_pkg::MAX_NODES];
    bfl_pkg::node_t slot_target_mem [bfl_pkg::MAX_SLOTS];
    bfl_pkg::link_t slot_next_mem [bfl_pkg::MAX_SLOTS];

    logic [bfl_pkg::MAX_NODES-1:0] head_vld_reg;
    logic                          head_hit_reg;
    bfl_pkg::link_t                head_data_reg;
    bfl_pkg::node_t                slot_target_reg;
    bfl_pkg::link_t                slot_next_reg;

    always_ff @(posedge clk)
    begin
        if (req.head_wr)
        begin
            head_mem[req.head_wr_addr] <= req.head_wr_link;
        end
        if (req.head_rd)
        begin
            head_data_reg <= head_mem[req.head_rd_addr];
        end
        if (req.slot_wr)
        begin
            slot_target_mem[req.slot_wr_addr] <= req.slot_wr_target;
            slot_next_mem[req.slot_wr_addr]   <= req.slot_wr_next;
        end
        if (req.slot_rd)
        begin
            slot_target_reg <= slot_target_mem[req.slot_rd_addr];
            slot_next_reg   <= slot_next_mem[req.slot_rd_addr];
        end
    end

    // An entry without its valid bit reads as an empty list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0;
            head_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.head_clear)
            begin
                head_vld_reg <= '0;
            end
            else if (req.head_wr)
            begin
                head_vld_reg[req.head_wr_addr] <= 1'b1;
            end
            if (req.head_rd)
            begin
                head_hit_reg <= head_vld_reg[req.head_rd_addr];
            end
        end
    end

    assign rsp.head_link   = head_hit_reg ? head_data_reg : '0;
    assign rsp.slot_target = slot_target_reg;
    assign rsp.slot_next   = slot_next_reg;

endmodule
`default_nettype wire

@@ hw/rtl/bfl_search.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfl_search - walk state
// Visited flags in flip-flops, the level store and the node queue as
// memories with registered read data.
// ----------------------------------------------------------------------------
module bfl_search
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bfl_pkg::srch_req_t req,
    output bfl_pkg::srch_rsp_t     rsp
);

    bfl_pkg::lvl_t  lvl_mem [bfl_pkg::MAX_NODES];
    bfl_pkg::node_t q_node_mem [bfl_pkg::MAX_NODES];
    bfl_pkg::lvl_t  q_lvl_mem [bfl_pkg::MAX_NODES];

    logic [bfl_pkg::MAX_NODES-1:0] visited_reg;
    logic [bfl_pkg::MAX_NODES-1:0] visited_next;
    bfl_pkg::lvl_t                 lvl_data_reg;
    bfl_pkg::node_t                q_node_reg;
    bfl_pkg::lvl_t                 q_lvl_reg;

    // Clear first, so a run can clear the flags and mark its root at once
    always_comb
    begin
        visited_next = req.vis_clear ? '0 : visited_reg;
        if (req.vis_set)
        begin
            visited_next[req.vis_set_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
        end
        else
        begin
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.lvl_wr)
        begin
            lvl_mem[req.lvl_wr_addr] <= req.lvl_wr_val;
        end
        if (req.lvl_rd)
        begin
            lvl_data_reg <= lvl_mem[req.lvl_rd_addr];
        end
        if (req.q_wr)
        begin
            q_node_mem[req.q_wr_addr] <= req.q_wr_node;
            q_lvl_mem[req.q_wr_addr]  <= req.q_wr_lvl;
        end
        if (req.q_rd)
        begin
            q_node_reg <= q_node_mem[req.q_rd_addr];
            q_lvl_reg  <= q_lvl_mem[req.q_rd_addr];
        end
    end

    assign rsp.visited   = visited_reg;
    assign rsp.lvl_rdata = lvl_data_reg;
    assign rsp.q_node    = q_node_reg;
    assign rsp.q_lvl     = q_lvl_reg;

endmodule
`default_nettype wire

@@ dv/bfs_level_finder_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_level_finder_test - self-checking bench for the BFS level finder
// Builds graphs edge by edge, runs searches from chosen roots and checks
// every returned node, level, last and overflow bit against a predictor
// of the graph store. Both handshakes idle at random. One long hold on the
// result side backs the block up.
// ----------------------------------------------------------------------------
module bfs_level_finder_test;

    import bfl_pkg::*;

    localparam int         CYCLE_LIMIT = 600000;
    localparam int         HOLD_CYCLES = 2500;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef struct {
        node_t node;
        lvl_t  hop;
        logic  fin;
        logic  ovf;
    } level_entry_t;

    class bfs_level_scoreboard;
        int unsigned  head_link [MAX_NODES];
        int unsigned  next_link [MAX_SLOTS];
        node_t        slot_dest [MAX_SLOTS];
        int unsigned  slot_count;
        logic         dropped_edge;
        level_entry_t due_levels [$];
        int unsigned  predicted;
        int unsigned  failures;

        function new();
            foreach (head_link[i])
                head_link[i] = 0;
            slot_count   = 0;
            dropped_edge = 1'b0;
            predicted    = 0;
            failures     = 0;
        endfunction

        function void add_slot(input node_t from, input node_t to);
            slot_dest[slot_count] = to;
            next_link[slot_count] = head_link[from];
            head_link[from]       = slot_count + 1;
            slot_count++;
        endfunction

        // Update the graph copy and queue the levels a run request yields
        function void take_request(input logic [1:0] m, input node_t a, input node_t b);
            logic         seen [MAX_NODES];
            lvl_t         depth [MAX_NODES];
            node_t        fifo [MAX_NODES];
            int unsigned  qh;
            int unsigned  qt;
            int unsigned  lnk;
            int           prior_count;
            node_t        cur;
            node_t        dst;
            level_entry_t e;
            qh = 0;
            qt = 0;
            if (m == MODE_EDGE) begin
                if (int'(a) < MAX_NODES && int'(b) < MAX_NODES) begin
                    if (slot_count + 2 > MAX_SLOTS)
                        dropped_edge = 1'b1;
                    else
                    begin
                        add_slot(a, b);
                        add_slot(b, a);
                    end
                end
            end
            else if (m == MODE_CLEAR)
            begin
                foreach (head_link[i])
                    head_link[i] = 0;
                slot_count = 0;
            end
            else if (m == MODE_RUN && int'(a) < MAX_NODES)
            begin
                foreach (seen[i])
                begin
                    seen[i]  = 1'b0;
                    depth[i] = '0;
                end
                seen[a]  = 1'b1;
                fifo[qt] = a;
                qt++;
                while (qh < qt)
                begin
                    cur = fifo[qh];
                    qh++;
                    lnk = head_link[cur];
                    while (lnk != 0 && lnk <= slot_count)
                    begin
                        dst = slot_dest[lnk - 1];
                        if (int'(dst) < MAX_NODES && !seen[dst] && qt < MAX_NODES)
                        begin
                            seen[dst]  = 1'b1;
                            depth[dst] = depth[cur] + 1'b1;
                            fifo[qt]   = dst;
                            qt++;
                        end
                        lnk = next_link[lnk - 1];
                    end
                end
                prior_count = due_levels.size();
                for (int i = 0; i < MAX_NODES; i++)
                begin
                    if (seen[i])
                    begin
                        e.node = node_t'(i);
                        e.hop  = depth[i];
                        e.fin  = 1'b0;
                        e.ovf  = dropped_edge;
                        due_levels.insert(due_levels.size(), e);
                        predicted++;
                    end
                end
                if (due_levels.size() > prior_count)
                    due_levels[due_levels.size() - 1].fin = 1'b1;
            end
        endfunction

        function void check_result(input node_t id, input lvl_t hop, input logic fin,
                                   input logic ovf);
            level_entry_t e;
            if (due_levels.size() == 0)
            begin
                $error("node_id: no result expected, actual %0d", id);
                failures++;
                return;
            end
            e = due_levels.pop_front();
            if (id !== e.node)
            begin
                $error("node_id: expected %0d, actual %0d", e.node, id);
                failures++;
            end
            if (hop !== e.hop)
            begin
                $error("hop_level: expected %0d, actual %0d", e.hop, hop);
                failures++;
            end
            if (fin !== e.fin)
            begin
                $error("last: expected %0b, actual %0b", e.fin, fin);
                failures++;
            end
            if (ovf !== e.ovf)
            begin
                $error("overflow: expected %0b, actual %0b", e.ovf, ovf);
                failures++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    logic [1:0] mode      = '0;
    node_t      node_a    = '0;
    node_t      node_b    = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    node_t      node_id;
    lvl_t       hop_level;
    logic       last;
    logic       overflow;

    bfs_level_scoreboard levels;
    int unsigned         cycle_count  = 0;
    int unsigned         useful_sent  = 0;
    int                  gap_pct      = 0;
    int                  stall_pct    = 0;
    bit                  res_hold_req = 1'b0;

    bfs_level_finder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .node_a    (node_a),
        .node_b    (node_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .node_id   (node_id),
        .hop_level (hop_level),
        .last      (last),
        .overflow  (overflow)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[bfs_level_finder] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            levels.check_result(node_id, hop_level, last, overflow);
    end

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_hold_req = 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
                res_ready <= 1'b1;
        end
    end

    function automatic node_t pick_node();
        return node_t'($urandom_range(0, MAX_NODES - 1));
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic issue(input logic [1:0] m, input node_t a, input node_t b);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        mode      <= m;
        node_a    <= a;
        node_b    <= b;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        levels.take_request(m, a, b);
        if (m != MODE_NONE)
            useful_sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (levels.due_levels.size() != 0);
    endtask

    task automatic link_pair(input node_t a, input node_t b);
        if ($urandom_range(0, 1))
            issue(MODE_EDGE, a, b);
        else
            issue(MODE_EDGE, b, a);
    endtask

    task automatic stray_request();
        case ($urandom_range(0, 2))
            0:       issue(MODE_NONE, pick_node(), pick_node());
            1:       issue(MODE_RUN, pick_node(), pick_node());
            default: issue(MODE_EDGE, pick_node(), pick_node());
        endcase
    endtask

    task automatic shuffle_nodes(output node_t order [MAX_NODES]);
        node_t tmp;
        int    j;
        for (int i = 0; i < MAX_NODES; i++)
            order[i] = node_t'(i);
        for (int i = MAX_NODES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
    endtask

    // Build a chain, tree or loose graph over random nodes, then search it
    task automatic graph_episode(input bit hold_receiver);
        node_t order [MAX_NODES];
        int    k;
        int    shape;
        int    runs;
        if ($urandom_range(0, 3) != 0)
            issue(MODE_CLEAR, pick_node(), pick_node());
        shuffle_nodes(order);
        k     = ($urandom_range(0, 7) == 0) ? MAX_NODES : $urandom_range(2, 12);
        shape = $urandom_range(0, 2);
        for (int i = 1; i < k; i++)
        begin
            case (shape)
                0:       link_pair(order[i - 1], order[i]);
                1:       link_pair(order[$urandom_range(0, i - 1)], order[i]);
                default: link_pair(order[$urandom_range(0, k - 1)],
                                   order[$urandom_range(0, k - 1)]);
            endcase
            if ($urandom_range(0, 11) == 0)
                stray_request();
        end
        if (hold_receiver)
            res_hold_req = 1'b1;
        runs = hold_receiver ? 4 : $urandom_range(1, 3);
        repeat (runs)
            issue(MODE_RUN, ($urandom_range(0, 4) == 0) ? pick_node()
                                                        : order[$urandom_range(0, k - 1)],
                  pick_node());
    endtask

    initial
    begin
        int unsigned start_sent;
        int          ep;
        levels = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        issue(MODE_RUN, 6'd0, 6'd0);        // empty graph: root alone
        issue(MODE_RUN, 6'd63, 6'd63);
        issue(MODE_EDGE, 6'd0, 6'd63);
        issue(MODE_EDGE, 6'd63, 6'd63);     // self loop
        issue(MODE_EDGE, 6'd63, 6'd0);      // duplicate, reversed
        issue(MODE_EDGE, 6'd5, 6'd0);
        issue(MODE_NONE, 6'd63, 6'd63);
        issue(MODE_RUN, 6'd63, 6'd0);
        issue(MODE_RUN, 6'd5, 6'd63);
        issue(MODE_EDGE, 6'd42, 6'd21);
        issue(MODE_EDGE, 6'd21, 6'd5);
        issue(MODE_RUN, 6'd42, 6'd42);
        issue(MODE_RUN, 6'd7, 6'd0);        // isolated root
        issue(MODE_CLEAR, 6'd63, 6'd63);
        issue(MODE_RUN, 6'd0, 6'd63);
        issue(MODE_NONE, 6'd0, 6'd0);
        issue(MODE_EDGE, 6'd1, 6'd2);
        issue(MODE_RUN, 6'd2, 6'd0);
        issue(MODE_CLEAR, 6'd0, 6'd0);

        start_sent = useful_sent;
        ep         = 0;
        while (useful_sent - start_sent < 40 || levels.predicted < 60 || ep < 3)
        begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            graph_episode(ep == 2);
            if (ep == 1 || $urandom_range(0, 2) == 0)
                drain();
            ep++;
        end

        gap_pct   = 0;
        stall_pct = 0;
        repeat (2)
            graph_episode(1'b0);

        cmd_valid <= 1'b0;
        while (levels.due_levels.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (levels.failures == 0)
            $display("[bfs_level_finder] OK");
        else
            $display("[bfs_level_finder] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
